### hdl/tpd_pkg.sv
package tpd_pkg;

  // Default sizing of the sequencer
  localparam int FIELD_COUNTER_WIDTH_DEF = 32;
  localparam int CADENCE_SLOTS_DEF       = 13;

  // Fixed field widths
  localparam int TS_W    = 63;
  localparam int RATE_W  = 20;
  localparam int CFG_W   = 20;
  localparam int PHASE_W = 4;

  // Nanoseconds per second and the width of ns_per_s * rate_den
  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam int KMUL_W = 50;
  // Divisor is 2 * rate_num
  localparam int DIV_W  = RATE_W + 1;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_CADENCE        = 3'd0,
    REG_CADENCE_OFFSET = 3'd1,
    REG_TOP_FIRST      = 3'd2,
    REG_ALLOW_REPEAT   = 3'd3,
    REG_RATE_NUM       = 3'd4,
    REG_RATE_DEN       = 3'd5
  } reg_idx_t;

  // Cadence codes
  localparam logic [2:0] CAD_1_1     = 3'd0;
  localparam logic [2:0] CAD_2_2     = 3'd1;
  localparam logic [2:0] CAD_2_3     = 3'd2;
  localparam logic [2:0] CAD_2_3_3_2 = 3'd3;
  localparam logic [2:0] CAD_EURO    = 3'd4;

  typedef struct packed {
    logic [2:0]        cadence;
    logic [3:0]        cadence_offset;
    logic              top_first;
    logic              allow_repeat_field;
    logic [RATE_W-1:0] rate_num;
    logic [RATE_W-1:0] rate_den;
  } cfg_t;

  // Status of the shared scaling unit
  typedef struct packed {
    logic busy;
    logic done;
  } scl_status_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_STEP,
    SQ_TS,
    SQ_DUR,
    SQ_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV
  } scl_state_t;

  // Fields that a cadence slot assigns to one frame; zero marks an empty slot
  function automatic logic [1:0] cad_fields(input logic [2:0] cadence,
                                            input logic [3:0] idx);
    logic [2:0] row;
    logic [1:0] f;
    row = (cadence > CAD_EURO) ? CAD_EURO : cadence;
    f = 2'd0;
    unique case (row)
      CAD_1_1:     f = (idx == 4'd0) ? 2'd1 : 2'd0;
      CAD_2_2:     f = (idx == 4'd0) ? 2'd2 : 2'd0;
      CAD_2_3: begin
        if (idx == 4'd0) f = 2'd2;
        else if (idx == 4'd1) f = 2'd3;
      end
      CAD_2_3_3_2: begin
        if (idx == 4'd0 || idx == 4'd3) f = 2'd2;
        else if (idx == 4'd1 || idx == 4'd2) f = 2'd3;
      end
      CAD_EURO: begin
        if (idx < 4'd11) f = 2'd2;
        else if (idx == 4'd11) f = 2'd3;
      end
      default: f = 2'd0;
    endcase
    return f;
  endfunction

endpackage

### hdl/tpd_scaler.sv
module tpd_scaler
  import tpd_pkg::*;
#(
  parameter int FIELD_COUNTER_WIDTH = FIELD_COUNTER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [FIELD_COUNTER_WIDTH-1:0] fields,
  input  logic [RATE_W-1:0]              rate_num,
  input  logic [RATE_W-1:0]              rate_den,
  output scl_status_t                    status,
  output logic [TS_W-1:0]                quot
);

  localparam int PROD_W = KMUL_W + FIELD_COUNTER_WIDTH;
  localparam int CNT_W  = $clog2(PROD_W);

  scl_state_t state, state_next;

  logic [KMUL_W-1:0]              kmul;
  logic [KMUL_W-1:0]              kprod;
  logic [FIELD_COUNTER_WIDTH-1:0] mplr;
  logic [PROD_W-1:0]              acc;
  logic [PROD_W-1:0]              mul_add;
  logic [DIV_W-1:0]               divisor;
  logic [DIV_W-1:0]               rem;
  logic [DIV_W:0]                 rem_sh;
  logic [DIV_W:0]                 rem_sub;
  logic                           ge;
  logic [DIV_W-1:0]               rem_next;
  logic [CNT_W-1:0]               cnt;
  logic                           done;

  // Scale factor ns_per_s * rate_den
  assign kprod = KMUL_W'(NS_PER_S) * KMUL_W'(rate_den);

  // One shift-add step, multiplier bits taken from the top
  assign mul_add = {acc[PROD_W-2:0], 1'b0} +
                   (mplr[FIELD_COUNTER_WIDTH-1] ? PROD_W'(kmul) : PROD_W'(0));

  // One restoring division step, dividend bits taken from the top
  assign rem_sh   = {rem, acc[PROD_W-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign rem_next = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (start) state_next = SC_MUL;
      SC_MUL:  if (cnt == CNT_W'(0)) state_next = SC_DIV;
      SC_DIV:  if (cnt == CNT_W'(0)) state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  // Load operands, multiply, then divide
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SC_IDLE: begin
          if (start) begin
            kmul    <= kprod;
            mplr    <= fields;
            acc     <= '0;
            divisor <= {rate_num, 1'b0};
            cnt     <= CNT_W'(FIELD_COUNTER_WIDTH - 1);
          end
        end
        SC_MUL: begin
          acc  <= mul_add;
          mplr <= {mplr[FIELD_COUNTER_WIDTH-2:0], 1'b0};
          if (cnt == CNT_W'(0)) begin
            cnt <= CNT_W'(PROD_W - 1);
            rem <= '0;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        SC_DIV: begin
          rem  <= rem_next;
          quot <= {quot[TS_W-2:0], ge};
          acc  <= {acc[PROD_W-2:0], 1'b0};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(0)) done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status.busy = (state != SC_IDLE);
  assign status.done = done;

endmodule

### hdl/tpd_seq.sv
module tpd_seq
  import tpd_pkg::*;
#(
  parameter int FIELD_COUNTER_WIDTH = FIELD_COUNTER_WIDTH_DEF,
  parameter int CADENCE_SLOTS       = CADENCE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic                           discont,
  input  logic                           ts_known,
  input  logic [TS_W-1:0]                in_timestamp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           weave_stored,
  output logic                           first_field_bottom,
  output logic [1:0]                     field_count,
  output logic                           tff_flag,
  output logic                           rff_flag,
  output logic                           time_known,
  output logic [TS_W-1:0]                out_timestamp,
  output logic [TS_W-1:0]                out_duration,
  output logic                           last_of_run,
  output logic                           sc_start,
  output logic [FIELD_COUNTER_WIDTH-1:0] sc_fields,
  input  scl_status_t                    sc_status,
  input  logic [TS_W-1:0]                sc_quot
);

  seq_state_t state, state_next;

  // Sequencer state
  logic [PHASE_W-1:0]             phase;
  logic [1:0]                     leftover;
  logic                           next_parity;
  logic [TS_W-1:0]                timebase;
  logic                           tb_set;
  logic [FIELD_COUNTER_WIDTH-1:0] fsb;

  // Per-frame work registers
  logic [1:0] sto;
  logic [1:0] cur;
  logic [1:0] cnt;
  logic       d_weave;
  logic       d_fb;
  logic [1:0] d_n;
  logic       d_last;
  logic       d_tk;
  logic [TS_W-1:0] q_ts;
  logic [TS_W-1:0] q_dur;
  logic       out_load;

  // Frame entry: discontinuity, rebase, cadence lookup
  logic [1:0]         lo_eff;
  logic               par_eff;
  logic               rebase;
  logic [1:0]         raw_f;
  logic               ph_wrap;
  logic [PHASE_W-1:0] ph_eff;
  logic [1:0]         cur_f;
  logic [PHASE_W-1:0] phase_adv;

  assign lo_eff    = discont ? 2'd0 : leftover;
  assign par_eff   = discont ? ~cfg.top_first : next_parity;
  assign rebase    = ts_known && (!tb_set || (lo_eff == 2'd0 && phase == cfg.cadence_offset));
  assign raw_f     = cad_fields(cfg.cadence, phase);
  assign ph_wrap   = ({1'b0, phase} >= 5'(CADENCE_SLOTS)) || (raw_f == 2'd0);
  assign ph_eff    = ph_wrap ? '0 : phase;
  assign cur_f     = cad_fields(cfg.cadence, ph_eff);
  assign phase_adv = ph_eff + PHASE_W'(1);

  // Descriptor step: weave, triple or pair
  logic [2:0] num;
  logic [2:0] num_n;
  logic       go;
  logic       weave;
  logic [1:0] sto_n;
  logic [1:0] cur_n;
  logic [1:0] n;
  logic       more;
  logic       tk;

  assign num = {1'b0, sto} + {1'b0, cur};
  assign go  = (num >= 3'd2) && (cnt < 2'd2);

  always_comb begin
    weave = 1'b0;
    sto_n = sto;
    cur_n = cur;
    n     = 2'd2;
    priority if (sto != 2'd0) begin
      weave = 1'b1;
      sto_n = sto - 2'd1;
      cur_n = cur - 2'd1;
    end else if (num >= 3'd3 && cfg.allow_repeat_field) begin
      cur_n = cur - 2'd3;
      n     = 2'd3;
    end else begin
      cur_n = cur - 2'd2;
    end
  end

  assign num_n = {1'b0, sto_n} + {1'b0, cur_n};
  assign more  = (num_n >= 3'd2) && (cnt == 2'd0);
  assign tk    = (cfg.rate_num != '0) && tb_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    sc_start   = 1'b0;
    sc_fields  = fsb;
    out_load   = 1'b0;
    unique case (state)
      SQ_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !action) state_next = SQ_STEP;
      end
      SQ_STEP: begin
        if (go) begin
          if (tk) begin
            sc_start   = 1'b1;
            state_next = SQ_TS;
          end else begin
            state_next = SQ_OUT;
          end
        end else begin
          state_next = SQ_IDLE;
        end
      end
      SQ_TS: begin
        sc_fields = FIELD_COUNTER_WIDTH'(d_n);
        if (sc_status.done) begin
          sc_start   = 1'b1;
          state_next = SQ_DUR;
        end
      end
      SQ_DUR: begin
        if (sc_status.done) state_next = SQ_OUT;
      end
      SQ_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = SQ_STEP;
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      leftover    <= 2'd0;
      next_parity <= 1'b0;
      timebase    <= '0;
      tb_set      <= 1'b0;
      fsb         <= '0;
      cnt         <= 2'd0;
      out_valid   <= 1'b0;
    end else begin
      // Drop the output once taken, hold it while stalled, refill on load
      out_valid <= out_load || (out_valid && out_stall);

      unique case (state)
        SQ_IDLE: begin
          if (in_valid) begin
            if (action) begin
              phase       <= cfg.cadence_offset;
              leftover    <= 2'd0;
              next_parity <= 1'b0;
              tb_set      <= 1'b0;
            end else begin
              if (rebase) begin
                timebase <= in_timestamp;
                tb_set   <= 1'b1;
                fsb      <= '0;
              end
              phase       <= phase_adv;
              next_parity <= par_eff;
              sto         <= lo_eff;
              cur         <= cur_f;
              cnt         <= 2'd0;
            end
          end
        end
        SQ_STEP: begin
          if (go) begin
            d_weave     <= weave;
            d_fb        <= next_parity;
            d_n         <= n;
            d_last      <= !more;
            d_tk        <= tk;
            sto         <= sto_n;
            cur         <= cur_n;
            cnt         <= cnt + 2'd1;
            fsb         <= fsb + FIELD_COUNTER_WIDTH'(n);
            next_parity <= next_parity ^ n[0];
            if (!tk) begin
              q_ts  <= '0;
              q_dur <= '0;
            end
          end else begin
            leftover <= cur;
          end
        end
        SQ_TS: begin
          if (sc_status.done) q_ts <= timebase + sc_quot;
        end
        SQ_DUR: begin
          if (sc_status.done) q_dur <= sc_quot;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      weave_stored       <= d_weave;
      first_field_bottom <= d_fb;
      field_count        <= d_n;
      tff_flag           <= ~d_fb;
      rff_flag           <= (d_n == 2'd3);
      time_known         <= d_tk;
      out_timestamp      <= q_ts;
      out_duration       <= q_dur;
      last_of_run        <= d_last;
    end
  end

  a_leftover_single: assert property (@(posedge clk) disable iff (rst)
    leftover < 2'd2)
    else $error("leftover field count above one");

  a_unknown_time_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !time_known |-> out_timestamp == '0 && out_duration == '0)
    else $error("timing fields set while timing unknown");

  a_weave_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && weave_stored |-> field_count == 2'd2)
    else $error("woven frame with other than two fields");

  a_scaler_owned: assert property (@(posedge clk) disable iff (rst)
    sc_status.busy |-> (state == SQ_TS || state == SQ_DUR))
    else $error("scaler busy outside timing steps");

endmodule

### hdl/telecine_pulldown_sequencer.sv
// A frame is taken while the sequencer is idle; each timed descriptor then
//   passes through the shared shift-add multiplier and bit-serial divider,
//   which scale the fields so far for the timestamp and then the frame's field
//   count for the duration in turn; without known timing the scaler is skipped.
// A new frame or flush is taken only in the idle state, once every descriptor of the last frame is out.
// Reset (synchronous, active high): configuration registers to their defaults, cadence state cleared.
module telecine_pulldown_sequencer
  import tpd_pkg::*;
#(
  parameter int FIELD_COUNTER_WIDTH = FIELD_COUNTER_WIDTH_DEF,
  parameter int CADENCE_SLOTS       = CADENCE_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             action,
  input  logic             discont,
  input  logic             ts_known,
  input  logic [TS_W-1:0]  in_timestamp,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             weave_stored,
  output logic             first_field_bottom,
  output logic [1:0]       field_count,
  output logic             tff_flag,
  output logic             rff_flag,
  output logic             time_known,
  output logic [TS_W-1:0]  out_timestamp,
  output logic [TS_W-1:0]  out_duration,
  output logic             last_of_run,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t                           cfg;
  logic                           sc_start;
  logic [FIELD_COUNTER_WIDTH-1:0] sc_fields;
  scl_status_t                    sc_status;
  logic [TS_W-1:0]                sc_quot;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cadence            <= CAD_2_3;
      cfg.cadence_offset     <= 4'd0;
      cfg.top_first          <= 1'b0;
      cfg.allow_repeat_field <= 1'b0;
      cfg.rate_num           <= '0;
      cfg.rate_den           <= RATE_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CADENCE:        cfg.cadence            <= cfg_data[2:0];
        REG_CADENCE_OFFSET: cfg.cadence_offset     <= cfg_data[3:0];
        REG_TOP_FIRST:      cfg.top_first          <= cfg_data[0];
        REG_ALLOW_REPEAT:   cfg.allow_repeat_field <= cfg_data[0];
        REG_RATE_NUM:       cfg.rate_num           <= cfg_data[RATE_W-1:0];
        REG_RATE_DEN:       cfg.rate_den           <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  tpd_seq #(
    .FIELD_COUNTER_WIDTH(FIELD_COUNTER_WIDTH),
    .CADENCE_SLOTS      (CADENCE_SLOTS)
  ) u_seq (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .discont           (discont),
    .ts_known          (ts_known),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .weave_stored      (weave_stored),
    .first_field_bottom(first_field_bottom),
    .field_count       (field_count),
    .tff_flag          (tff_flag),
    .rff_flag          (rff_flag),
    .time_known        (time_known),
    .out_timestamp     (out_timestamp),
    .out_duration      (out_duration),
    .last_of_run       (last_of_run),
    .sc_start          (sc_start),
    .sc_fields         (sc_fields),
    .sc_status         (sc_status),
    .sc_quot           (sc_quot)
  );

  tpd_scaler #(
    .FIELD_COUNTER_WIDTH(FIELD_COUNTER_WIDTH)
  ) u_scaler (
    .clk     (clk),
    .rst     (rst),
    .start   (sc_start),
    .fields  (sc_fields),
    .rate_num(cfg.rate_num),
    .rate_den(cfg.rate_den),
    .status  (sc_status),
    .quot    (sc_quot)
  );

endmodule
